// ===== src/iirl_pkg.sv =====
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared sizes, command and status codes and control structs for the
// indexed insert/remove list.
// ----------------------------------------------------------------------------
package iirl_pkg;

  localparam int DEPTH     = 16;
  localparam int WIDTH     = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam int CMD_W     = 3;
  localparam int POS_W     = 5;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Per-cycle instruction broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [IDX_W-1:0] at;
  } cell_ctl_t;

  // Outcome of the command being accepted this cycle.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_idx;
  } cmd_res_t;

endpackage

// ===== src/iirl_if.sv =====
// ----------------------------------------------------------------------------
// iirl_if
// Valid/ready channels carrying list commands and their results.
// ----------------------------------------------------------------------------
interface iirl_req_if import iirl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface iirl_rsp_if import iirl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VAL_W-1:0]     read_value;
  logic [STAT_W-1:0]    status;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

// ===== src/indexed_insert_remove_list_top.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top
// Ordered list of DEPTH words with push, pop, insert, remove and get.
// ----------------------------------------------------------------------------
// Commands arrive on the request channel (command, position, value) and each
// produces exactly one word on the response channel (read_value, status,
// count), in order. The list is a row of cells, one entry each; insert and
// remove move every later entry to its neighbour in the same cycle.
// The response is registered and valid in the cycle after the request is taken.
// Throughput: one command per cycle; the single response register sets it.
// A new request is taken while the previous response is being taken, so a
// steady stream moves at full rate. If the receiver stalls, the response
// register holds its word and request.ready drops until it is taken.
// Reset clears the entry count and the response valid flag; list contents
// are not cleared and are only read below the count. Flagged commands (full,
// empty, index out of range) change nothing and return read_value zero.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_top import iirl_pkg::*; (
  input logic        clk,
  input logic        rst,
  iirl_req_if.sink   request,
  iirl_rsp_if.source response
);

  cell_ctl_t              ctl;
  cmd_res_t               res;
  logic                   fire;
  logic [WIDTH-1:0]       cell_data [DEPTH];
  logic [WIDTH+VAL_W-1:0] value_ext;
  logic [WIDTH+VAL_W-1:0] rd_ext;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign request.ready = !response.valid || response.ready;
  assign fire          = request.valid && request.ready;
  assign value_ext     = {{WIDTH{1'b0}}, request.value};

  iirl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .command  (request.command),
    .position (request.position),
    .ctl      (ctl),
    .res      (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left;
    logic [WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    iirl_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (IDX_W'(i)),
      .left  (left),
      .right (right),
      .value (value_ext[WIDTH-1:0]),
      .data  (cell_data[i])
    );
  end

  assign rd_ext  = {{VAL_W{1'b0}}, cell_data[res.rd_idx]};
  assign cnt_ext = {{CNT_OUT_W{1'b0}}, res.count};

  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (fire) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      response.read_value <= res.rd_en ? rd_ext[VAL_W-1:0] : '0;
      response.status     <= res.status;
      response.count      <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

endmodule

// ===== src/iirl_cell.sv =====
// ----------------------------------------------------------------------------
// iirl_cell
// One list slot: holds, loads the new word, or takes a neighbour's word.
// ----------------------------------------------------------------------------
module iirl_cell import iirl_pkg::*; (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  logic [WIDTH-1:0] left,
  input  logic [WIDTH-1:0] right,
  input  logic [WIDTH-1:0] value,
  output logic [WIDTH-1:0] data
);

  always_ff @(posedge clk) begin
    if (ctl.ins && idx > ctl.at) begin
      data <= left;
    end else if (ctl.ins && idx == ctl.at) begin
      data <= value;
    end else if (ctl.rem && idx >= ctl.at) begin
      data <= right;
    end
  end

endmodule

// ===== src/iirl_ctrl.sv =====
// ----------------------------------------------------------------------------
// iirl_ctrl
// Command decode, status checks and the entry count register.
// ----------------------------------------------------------------------------
module iirl_ctrl import iirl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [CMD_W-1:0] command,
  input  logic [POS_W-1:0] position,
  output cell_ctl_t        ctl,
  output cmd_res_t         res
);

  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  logic [CNT_W-1:0]       cnt_dec;
  logic [CNT_W+POS_W-1:0] pos_ext;
  logic [CNT_W+POS_W-1:0] cnt_ext;
  logic                   full;

  assign pos_ext = {{CNT_W{1'b0}}, position};
  assign cnt_ext = {{POS_W{1'b0}}, count};
  assign cnt_dec = count - 1'b1;
  assign full    = (count >= CNT_W'(DEPTH));

  always_comb begin
    res.status = ST_OK;
    res.rd_en  = 1'b0;
    res.rd_idx = pos_ext[IDX_W-1:0];
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    ctl.at     = pos_ext[IDX_W-1:0];
    count_next = count;
    unique case (command)
      CMD_PUSH: begin
        ctl.at = count[IDX_W-1:0];
        if (full) begin
          res.status = ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_POP: begin
        res.rd_idx = cnt_dec[IDX_W-1:0];
        if (count == '0) begin
          res.status = ST_EMPTY;
        end else begin
          res.rd_en  = 1'b1;
          count_next = cnt_dec;
        end
      end
      CMD_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          ctl.ins    = 1'b1;
          count_next = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          ctl.rem    = 1'b1;
          count_next = cnt_dec;
        end
      end
      CMD_GET: begin
        if (pos_ext >= cnt_ext) begin
          res.status = ST_RANGE;
        end else begin
          res.rd_en = 1'b1;
        end
      end
      default: ;
    endcase
    // drop the shift unless the word is actually taken
    ctl.ins   = ctl.ins & fire;
    ctl.rem   = ctl.rem & fire;
    res.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_flag_holds: assert property (@(posedge clk) disable iff (rst)
    fire && (res.status != ST_OK) |=> count == $past(count))
    else $error("flagged command changed the count");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("count moved without a command");

  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ins && ctl.rem))
    else $error("insert and remove shift together");
`endif

endmodule

// ===== tb/indexed_insert_remove_list_top_test.sv =====
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top_test
// Self-checking bench for the indexed insert/remove list.
// ----------------------------------------------------------------------------
// Runs a directed table of list commands, covering the empty and full list,
// boundary positions and unused command codes. A long random run follows,
// alternating between fill-biased and drain-biased command mixes. A mirror
// of the list predicts untyped response words, and each response is checked
// field by field in order. Both channels idle in random bursts. The receiver
// also holds off once for a long stretch, so that the request side stalls.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_top_test;
  import iirl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

  localparam int RANDOM_WORDS = 1200;
  localparam int CALM_TAIL    = 150;
  localparam int SEGMENT      = 150;
  localparam int LONG_HOLD    = 60;
  localparam int HOLD_AT      = 160;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic [VAL_W-1:0]     read_value;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] count;
  } list_reply_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
    logic [4:0]       repeats;
    logic             typed;
    list_reply_t      reply;
  } list_row_t;

  localparam int ROWS = 24;

  // Rows marked typed carry their response; the rest follow the mirror.
  localparam list_row_t DIRECTED_ROWS [ROWS] = '{
    '{CMD_POP,       5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, ST_EMPTY, 5'd0}},
    '{CMD_GET,       5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
    '{CMD_REMOVE,    5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
    '{CMD_INSERT,    5'd1,  32'h1234,      5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd0}},
    '{CMD_INSERT,    5'd0,  32'hFFFFFFFF,  5'd1,  1'b1, '{32'h0, ST_OK,    5'd1}},
    '{CMD_PUSH,      5'd0,  32'h0,         5'd1,  1'b1, '{32'h0, ST_OK,    5'd2}},
    '{CMD_GET,       5'd31, 32'h0,         5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd2}},
    '{CMD_GET,       5'd0,  32'h0,         5'd1,  1'b1, '{32'hFFFFFFFF, ST_OK, 5'd2}},
    '{CMD_UNUSED_LO, 5'd31, 32'hFFFFFFFF,  5'd1,  1'b1, '{32'h0, ST_OK,    5'd2}},
    '{CMD_UNUSED_HI, 5'd0,  32'hFFFFFFFF,  5'd1,  1'b1, '{32'h0, ST_OK,    5'd2}},
    '{CMD_INSERT,    5'd1,  32'h55555555,  5'd1,  1'b0, '0},
    '{CMD_REMOVE,    5'd0,  32'h0,         5'd1,  1'b0, '0},
    '{CMD_PUSH,      5'd0,  32'hAAAAAAAA,  5'd14, 1'b0, '0},
    '{CMD_PUSH,      5'd0,  32'h1,         5'd1,  1'b1, '{32'h0, ST_FULL,  5'd16}},
    '{CMD_INSERT,    5'd16, 32'h1,         5'd1,  1'b1, '{32'h0, ST_FULL,  5'd16}},
    '{CMD_INSERT,    5'd0,  32'h1,         5'd1,  1'b1, '{32'h0, ST_FULL,  5'd16}},
    '{CMD_GET,       5'd15, 32'h0,         5'd1,  1'b0, '0},
    '{CMD_GET,       5'd16, 32'h0,         5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd16}},
    '{CMD_REMOVE,    5'd15, 32'h0,         5'd1,  1'b0, '0},
    '{CMD_INSERT,    5'd15, 32'h80000001,  5'd1,  1'b0, '0},
    '{CMD_REMOVE,    5'd16, 32'h0,         5'd1,  1'b1, '{32'h0, ST_RANGE, 5'd16}},
    '{CMD_POP,       5'd0,  32'h0,         5'd1,  1'b0, '0},
    '{CMD_UNUSED_MID,5'd16, 32'h0,         5'd1,  1'b0, '0},
    '{CMD_GET,       5'd0,  32'h0,         5'd1,  1'b0, '0}
  };

  logic clk;
  logic rst;

  iirl_req_if request ();
  iirl_rsp_if response ();

  indexed_insert_remove_list_top DUT (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .response (response)
  );

  logic [WIDTH-1:0] list_mirror [DEPTH];
  int               list_len;
  list_reply_t      pending_replies [$];
  int               mismatches;
  int               cycle_count;
  bit               idling_on;
  bit               hold_off_pending;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mirror of the list: apply one command and return the response it gives.
  function automatic list_reply_t step_list(input logic [CMD_W-1:0] cmd,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VAL_W-1:0] val);
    list_reply_t r;
    int          at;
    int          i;
    at = int'(pos);
    r.read_value = '0;
    r.status     = ST_OK;
    case (cmd)
      CMD_PUSH: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mirror[list_len] = val[WIDTH-1:0];
          list_len++;
        end
      end
      CMD_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_len--;
          r.read_value = list_mirror[list_len];
        end
      end
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (at > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_len; i > at; i--) list_mirror[i] = list_mirror[i-1];
          list_mirror[at] = val[WIDTH-1:0];
          list_len++;
        end
      end
      CMD_REMOVE: begin
        if (at >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = at; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i+1];
          list_len--;
        end
      end
      CMD_GET: begin
        if (at >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = list_mirror[at];
        end
      end
      default: ;
    endcase
    r.count = list_len[CNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one word, hold it until taken, then log the response it must give.
  task automatic offer_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val, input logic typed,
                            input list_reply_t typed_reply);
    list_reply_t predicted;
    request.valid    <= 1'b1;
    request.command  <= cmd;
    request.position <= pos;
    request.value    <= val;
    do @(posedge clk); while (!request.ready);
    predicted = step_list(cmd, pos, val);
    pending_replies.push_back(typed ? typed_reply : predicted);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      request.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               pick;
    bit               filling;

    rst              = 1'b1;
    request.valid    = 1'b0;
    request.command  = CMD_PUSH;
    request.position = '0;
    request.value    = '0;
    list_len         = 0;
    mismatches       = 0;
    idling_on        = 1'b1;
    hold_off_pending = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[r]) begin
      repeat (DIRECTED_ROWS[r].repeats) begin
        sender_gap();
        offer_word(DIRECTED_ROWS[r].command, DIRECTED_ROWS[r].position,
                   DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed,
                   DIRECTED_ROWS[r].reply);
      end
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      idling_on = ((n / SEGMENT) % 3 != 1) && (n < RANDOM_WORDS - CALM_TAIL);
      if (n == HOLD_AT) hold_off_pending = 1'b1;
      // Alternate between filling and draining so both ends get visited.
      filling = ((n / 50) % 2) == 0;
      pick = $urandom_range(0, 99);
      if (pick < 3)
        cmd = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else if (pick < (filling ? 35 : 15))
        cmd = CMD_PUSH;
      else if (pick < (filling ? 60 : 27))
        cmd = CMD_INSERT;
      else if (pick < (filling ? 72 : 50))
        cmd = CMD_POP;
      else if (pick < (filling ? 84 : 75))
        cmd = CMD_REMOVE;
      else
        cmd = CMD_GET;
      pick = $urandom_range(0, 9);
      if (pick < 8)
        pos = POS_W'($urandom_range(0, list_len));
      else if (pick == 8)
        pos = POS_W'($urandom_range(0, 31));
      else
        pos = POS_W'(list_len);
      pick = $urandom_range(0, 15);
      if (pick == 0)
        val = '0;
      else if (pick == 1)
        val = '1;
      else
        val = $urandom;
      sender_gap();
      offer_word(cmd, pos, val, 1'b0, '0);
    end
    request.valid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left     = 0;
    response.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        stall_left       = LONG_HOLD;
        hold_off_pending = 1'b0;
      end
      if (stall_left > 0) begin
        response.ready <= 1'b0;
        stall_left--;
      end else begin
        response.ready <= 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 18);
      end
    end
  end

  always @(posedge clk) begin : check_replies
    list_reply_t want;
    if (!rst && response.valid && response.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected response, count", 32'(response.count), '0);
      end else begin
        want = pending_replies.pop_front();
        if (response.read_value !== want.read_value)
          report_mismatch("read_value", response.read_value, want.read_value);
        if (response.status !== want.status)
          report_mismatch("status", 32'(response.status), 32'(want.status));
        if (response.count !== want.count)
          report_mismatch("count", 32'(response.count), 32'(want.count));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
